// ----- hw/rtl/dmd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmd_pkg: shared types and constants for the date-minus-days block
// Field widths, datapath commands and status, calendar tables and the
// constants of the shared shift-subtract divider.
// ----------------------------------------------------------------------------
package dmd_pkg;

  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int BACK_W  = 22;
  localparam int SER_W   = 23;
  localparam int YCNT_W  = 15;
  localparam int QUO_W   = 8;
  localparam int CNT_W   = 3;
  localparam int MAXY_W  = 17;

  localparam int YEAR_DAYS   = 365;
  localparam int YEARS_400   = 400;
  localparam int YEARS_100   = 100;
  localparam int YEARS_4     = 4;
  localparam int CENT_LAST   = 99;
  localparam int QUAD_LAST   = 24;
  localparam int LAST_MONTH  = 12;
  localparam int FEBRUARY    = 2;

  localparam logic [SER_W-1:0] DAYS_400Y = SER_W'(146097);
  localparam logic [SER_W-1:0] DAYS_100Y = SER_W'(36524);
  localparam logic [SER_W-1:0] DAYS_4Y   = SER_W'(1461);
  localparam logic [SER_W-1:0] DAYS_1Y   = SER_W'(YEAR_DAYS);
  localparam logic [SER_W-1:0] CENT_DIV  = SER_W'(YEARS_100);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SER_BASE,
    OP_SER_ADD,
    OP_SUB,
    OP_YEAR,
    OP_MON_STEP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    DIV_CENT,
    DIV_400Y,
    DIV_100Y,
    DIV_4Y,
    DIV_1Y
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic borrow;
    logic mon_last;
  } dp_stat_t;

  // number of quotient bits minus one
  function automatic logic [CNT_W-1:0] div_top(input div_sel_t sel);
    logic [CNT_W-1:0] k;
    case (sel)
      DIV_CENT: k = CNT_W'(7);
      DIV_400Y: k = CNT_W'(5);
      DIV_100Y: k = CNT_W'(2);
      DIV_4Y:   k = CNT_W'(4);
      DIV_1Y:   k = CNT_W'(2);
      default:  k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [SER_W-1:0] div_base(input div_sel_t sel);
    logic [SER_W-1:0] d;
    case (sel)
      DIV_CENT: d = CENT_DIV;
      DIV_400Y: d = DAYS_400Y;
      DIV_100Y: d = DAYS_100Y;
      DIV_4Y:   d = DAYS_4Y;
      DIV_1Y:   d = DAYS_1Y;
      default:  d = DAYS_1Y;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                     n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dmd_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmd_req_if: request channel
// Starting date and day count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmd_req_if;
  import dmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  start_day;
  logic [MON_W-1:0]  start_month;
  logic [YEAR_W-1:0] start_year;
  logic [BACK_W-1:0] days_back;

  modport source (output valid, start_day, start_month, start_year, days_back,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, days_back,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dmd_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmd_rsp_if: result channel
// Resulting date and clamp flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmd_rsp_if;
  import dmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  result_day;
  logic [MON_W-1:0]  result_month;
  logic [YEAR_W-1:0] result_year;
  logic              clamped;

  modport source (output valid, result_day, result_month, result_year, clamped,
                  input ready);
  modport sink   (input valid, result_day, result_month, result_year, clamped,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dmd_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmd_datapath: serial day arithmetic
// Date to serial number, subtraction, shared shift-subtract divider for the
// century and 400/100/4/1-year splits, month walk and the result register.
// ----------------------------------------------------------------------------
module dmd_datapath #(
  parameter int MAX_YEAR = 9999
) (
  input  wire                        clk,
  input  wire                        rst,
  input  dmd_pkg::dp_cmd_t           cmd,
  output dmd_pkg::dp_stat_t          stat,
  input  wire [dmd_pkg::DAY_W-1:0]   start_day,
  input  wire [dmd_pkg::MON_W-1:0]   start_month,
  input  wire [dmd_pkg::YEAR_W-1:0]  start_year,
  input  wire [dmd_pkg::BACK_W-1:0]  days_back,
  output logic [dmd_pkg::DAY_W-1:0]  result_day,
  output logic [dmd_pkg::MON_W-1:0]  result_month,
  output logic [dmd_pkg::YEAR_W-1:0] result_year,
  output logic                       clamped
);
  import dmd_pkg::*;

  localparam logic [MAXY_W-1:0] MAX_Y = MAXY_W'(MAX_YEAR);

  logic [YEAR_W-1:0] p;
  logic [MON_W-1:0]  m_r;
  logic [DAY_W-1:0]  d_r;
  logic [BACK_W-1:0] back_r;
  logic [SER_W-1:0]  rem;
  logic [SER_W-1:0]  ds;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;
  logic [QUO_W-1:0]  qc;
  logic [6:0]        remc;
  logic              leap_in;
  logic              clamp_r;
  logic [5:0]        q400;
  logic [1:0]        q100;
  logic [4:0]        q4;
  logic [1:0]        q1;
  logic [YCNT_W-1:0] year;
  logic [MON_W-1:0]  mon;
  logic              leap_y;

  logic [MON_W-1:0]  m_c;
  logic [YEAR_W-1:0] y_c;
  logic              ge;
  logic [SER_W-1:0]  rem_step;
  logic [QUO_W-1:0]  quo_step;
  logic              fix;
  logic [SER_W:0]    diff;
  logic [DAY_W-1:0]  len;

  always_comb begin
    if (start_month == '0) begin
      m_c = MON_W'(1);
    end else if (start_month > MON_W'(LAST_MONTH)) begin
      m_c = MON_W'(LAST_MONTH);
    end else begin
      m_c = start_month;
    end
    if (start_year == '0) begin
      y_c = YEAR_W'(1);
    end else if ({{(MAXY_W-YEAR_W){1'b0}}, start_year} > MAX_Y) begin
      y_c = MAX_Y[YEAR_W-1:0];
    end else begin
      y_c = start_year;
    end
  end

  assign ge       = (rem >= ds);
  assign rem_step = ge ? (rem - ds) : rem;
  assign quo_step = {quo[QUO_W-2:0], ge};
  assign fix      = ((cmd.sel == DIV_100Y) || (cmd.sel == DIV_1Y)) && quo_step[2];
  assign diff     = {1'b0, rem} - {{(SER_W-BACK_W+1){1'b0}}, back_r} - (SER_W+1)'(1);
  assign len      = month_len(mon, leap_y);

  assign stat.div_last = (cnt == '0);
  assign stat.borrow   = diff[SER_W];
  assign stat.mon_last = (rem < SER_W'(len)) || (mon == MON_W'(LAST_MONTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      clamp_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          p       <= y_c - YEAR_W'(1);
          m_r     <= m_c;
          d_r     <= start_day;
          back_r  <= days_back;
          rem     <= SER_W'(y_c - YEAR_W'(1));
          clamp_r <= 1'b0;
        end
        OP_DIV_INIT: begin
          ds  <= div_base(cmd.sel) << div_top(cmd.sel);
          cnt <= div_top(cmd.sel);
          quo <= '0;
        end
        OP_DIV_STEP: begin
          ds  <= ds >> 1;
          cnt <= cnt - CNT_W'(1);
          quo <= quo_step;
          if ((cnt == '0) && fix) begin
            rem <= div_base(cmd.sel);
          end else begin
            rem <= rem_step;
          end
          if (cnt == '0) begin
            case (cmd.sel)
              DIV_CENT: begin
                qc   <= quo_step;
                remc <= rem_step[6:0];
              end
              DIV_400Y: q400 <= quo_step[5:0];
              DIV_100Y: q100 <= fix ? 2'd3 : quo_step[1:0];
              DIV_4Y:   q4   <= quo_step[4:0];
              DIV_1Y:   q1   <= fix ? 2'd3 : quo_step[1:0];
              default:  q1   <= q1;
            endcase
          end
        end
        OP_SER_BASE: begin
          rem <= SER_W'(p) * SER_W'(YEAR_DAYS) + SER_W'(p >> 2) - SER_W'(qc)
                 + SER_W'(qc >> 2);
          leap_in <= (p[1:0] == 2'b11) &&
                     !((remc == 7'(CENT_LAST)) && (qc[1:0] != 2'b11));
        end
        OP_SER_ADD: begin
          rem <= rem + SER_W'(days_before_month(m_r))
                 + SER_W'(leap_in && (m_r > MON_W'(FEBRUARY))) + SER_W'(d_r);
        end
        OP_SUB: begin
          if (diff[SER_W]) begin
            clamp_r <= 1'b1;
          end else begin
            rem <= diff[SER_W-1:0];
          end
        end
        OP_YEAR: begin
          year   <= YCNT_W'(q400) * YCNT_W'(YEARS_400) + YCNT_W'(q100) * YCNT_W'(YEARS_100)
                    + YCNT_W'(q4) * YCNT_W'(YEARS_4) + YCNT_W'(q1) + YCNT_W'(1);
          leap_y <= (q1 == 2'd3) && !((q4 == 5'(QUAD_LAST)) && (q100 != 2'd3));
          mon    <= MON_W'(1);
        end
        OP_MON_STEP: begin
          if (!stat.mon_last) begin
            rem <= rem - SER_W'(len);
            mon <= mon + MON_W'(1);
          end
        end
        OP_OUT: begin
          if (clamp_r) begin
            result_day   <= DAY_W'(1);
            result_month <= MON_W'(1);
            result_year  <= YEAR_W'(1);
          end else begin
            result_day   <= rem[DAY_W-1:0] + DAY_W'(1);
            result_month <= mon;
            result_year  <= year[YEAR_W-1:0];
          end
          clamped <= clamp_r;
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dmd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmd_ctrl: sequencer
// Steps the datapath through date-to-serial, subtraction, the four
// divisions and the month walk; owns the channel handshakes.
// ----------------------------------------------------------------------------
module dmd_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output dmd_pkg::dp_cmd_t   cmd,
  input  dmd_pkg::dp_stat_t  stat
);
  import dmd_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CINIT = 17'h00002,
    S_CDIV  = 17'h00004,
    S_BASE  = 17'h00008,
    S_ADD   = 17'h00010,
    S_SUB   = 17'h00020,
    S_I400  = 17'h00040,
    S_R400  = 17'h00080,
    S_I100  = 17'h00100,
    S_R100  = 17'h00200,
    S_I4    = 17'h00400,
    S_R4    = 17'h00800,
    S_I1    = 17'h01000,
    S_R1    = 17'h02000,
    S_YEAR  = 17'h04000,
    S_MON   = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.sel    = DIV_CENT;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_CDIV;
      end
      S_CDIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_last) state_next = S_BASE;
      end
      S_BASE: begin
        cmd.op     = OP_SER_BASE;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_SER_ADD;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.op     = OP_SUB;
        state_next = stat.borrow ? S_DONE : S_I400;
      end
      S_I400: begin
        cmd.op     = OP_DIV_INIT;
        cmd.sel    = DIV_400Y;
        state_next = S_R400;
      end
      S_R400: begin
        cmd.op  = OP_DIV_STEP;
        cmd.sel = DIV_400Y;
        if (stat.div_last) state_next = S_I100;
      end
      S_I100: begin
        cmd.op     = OP_DIV_INIT;
        cmd.sel    = DIV_100Y;
        state_next = S_R100;
      end
      S_R100: begin
        cmd.op  = OP_DIV_STEP;
        cmd.sel = DIV_100Y;
        if (stat.div_last) state_next = S_I4;
      end
      S_I4: begin
        cmd.op     = OP_DIV_INIT;
        cmd.sel    = DIV_4Y;
        state_next = S_R4;
      end
      S_R4: begin
        cmd.op  = OP_DIV_STEP;
        cmd.sel = DIV_4Y;
        if (stat.div_last) state_next = S_I1;
      end
      S_I1: begin
        cmd.op     = OP_DIV_INIT;
        cmd.sel    = DIV_1Y;
        state_next = S_R1;
      end
      S_R1: begin
        cmd.op  = OP_DIV_STEP;
        cmd.sel = DIV_1Y;
        if (stat.div_last) state_next = S_YEAR;
      end
      S_YEAR: begin
        cmd.op     = OP_YEAR;
        state_next = S_MON;
      end
      S_MON: begin
        cmd.op = OP_MON_STEP;
        if (stat.mon_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_OUT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/date_minus_days.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_minus_days: Gregorian date minus a day count
// Maps a date to a serial day number, subtracts the count and maps back,
// clamping at 0001-01-01.
// ----------------------------------------------------------------------------
// One request is worked at a time. The result is loaded into the output
// register once any earlier result there has been taken, and the register
// holds it until taken; req is ready again from the edge that loads the
// result. Run time is set by one shared shift-subtract divider, one
// quotient bit per cycle (8 bits for the century split of the start year,
// then 6, 3, 5 and 3 bits for the 400-, 100-, 4- and 1-year splits), and a
// month walk of one month per cycle. Month and year inputs out of range are
// pulled into range; a day past the month end rolls forward.
module date_minus_days #(
  parameter int MAX_YEAR = 9999
) (
  input wire        clk,
  input wire        rst,
  dmd_req_if.sink   req,
  dmd_rsp_if.source rsp
);
  import dmd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  dmd_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .start_day    (req.start_day),
    .start_month  (req.start_month),
    .start_year   (req.start_year),
    .days_back    (req.days_back),
    .result_day   (rsp.result_day),
    .result_month (rsp.result_month),
    .result_year  (rsp.result_year),
    .clamped      (rsp.clamped)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/dmd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmd_checker: port-level checks
// Watches the request and result channels of date_minus_days.
// ----------------------------------------------------------------------------
module dmd_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        req_valid,
  input wire                        req_ready,
  input wire                        rsp_valid,
  input wire                        rsp_ready,
  input wire [dmd_pkg::DAY_W-1:0]   result_day,
  input wire [dmd_pkg::MON_W-1:0]   result_month,
  input wire [dmd_pkg::YEAR_W-1:0]  result_year,
  input wire                        clamped
);
  import dmd_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result_day) &&
      $stable(result_month) && $stable(result_year) && $stable(clamped)))
    else $error("result changed while stalled");

  a_clamp_first_day: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && clamped) |-> (result_day == DAY_W'(1) &&
      result_month == MON_W'(1) && result_year == YEAR_W'(1)))
    else $error("clamped result is not 0001-01-01");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (result_day != '0 && result_month != '0 &&
      result_month <= MON_W'(LAST_MONTH) && result_year != '0))
    else $error("result date out of range");

  // no result right after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !$rose(rsp_valid))
    else $error("result appeared one cycle after request");

endmodule

bind date_minus_days dmd_checker u_dmd_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .result_day   (rsp.result_day),
  .result_month (rsp.result_month),
  .result_year  (rsp.result_year),
  .clamped      (rsp.clamped)
);
`default_nettype wire

// ----- verif/date_sub_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_sub_checker: result checker for date_minus_days
// Watches the request and result channels. Each accepted request is run
// through a behavioral calendar model and the expected date is queued; each
// accepted result is compared field by field with the oldest queued date.
// ----------------------------------------------------------------------------
module date_sub_checker #(
  parameter int MAX_YEAR = 9999
) (
  input  wire         clk,
  input  wire         rst,
  dmd_req_if          req_mon,
  dmd_rsp_if          rsp_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  import dmd_pkg::*;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] year;
    logic              clamped;
  } date_res_t;

  date_res_t expected_dates[$];

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m,
                                                input int unsigned y);
    int unsigned n;
    case (m)
      2:             n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic date_res_t subtract_days(input logic [DAY_W-1:0]  d,
                                              input logic [MON_W-1:0]  m,
                                              input logic [YEAR_W-1:0] y,
                                              input logic [BACK_W-1:0] back);
    int unsigned mm, yy, p, serial, n, r, q400, q100, q4, q1, yr, mo, len;
    date_res_t   res;
    mm = m;
    yy = y;
    if (mm < 1) mm = 1;
    if (mm > 12) mm = 12;
    if (yy < 1) yy = 1;
    if (yy > MAX_YEAR) yy = MAX_YEAR;
    p = yy - 1;
    serial = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned i = 1; i < mm; i++) serial += days_in_month(i, yy);
    serial += d;
    res.day     = DAY_W'(1);
    res.mon     = MON_W'(1);
    res.year    = YEAR_W'(1);
    res.clamped = 1'b0;
    if (serial < int'(back) + 1) begin
      res.clamped = 1'b1;
    end else begin
      n = serial - back - 1;
      q400 = n / 146097;
      r = n % 146097;
      q100 = r / 36524;
      if (q100 > 3) q100 = 3;
      r -= q100 * 36524;
      q4 = r / 1461;
      r %= 1461;
      q1 = r / 365;
      if (q1 > 3) q1 = 3;
      r -= q1 * 365;
      yr = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
      mo = 1;
      len = days_in_month(mo, yr);
      while (r >= len && mo < 12) begin
        r -= len;
        mo++;
        len = days_in_month(mo, yr);
      end
      res.day  = DAY_W'(r + 1);
      res.mon  = MON_W'(mo);
      res.year = YEAR_W'(yr);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    date_res_t want;
    date_res_t got;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_dates.push_back(subtract_days(req_mon.start_day, req_mon.start_month,
                                               req_mon.start_year, req_mon.days_back));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.day     = rsp_mon.result_day;
        got.mon     = rsp_mon.result_month;
        got.year    = rsp_mon.result_year;
        got.clamped = rsp_mon.clamped;
        if (expected_dates.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: result with no request pending: %0d-%0d-%0d clamped=%0b",
                     got.year, got.mon, got.day, got.clamped);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_dates.pop_front();
          if (got.day != want.day || got.mon != want.mon || got.year != want.year ||
              got.clamped != want.clamped) begin
            if (fail_count < 10)
              $display("ERROR: expected %0d-%0d-%0d clamped=%0b, got %0d-%0d-%0d clamped=%0b",
                       want.year, want.mon, want.day, want.clamped,
                       got.year, got.mon, got.day, got.clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_dates.size();
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_date_minus_days.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_date_minus_days: testbench for date_minus_days
// Drives directed calendar corner cases (leap days, century years, the
// first and last supported dates, clamping, out-of-range fields) and then
// random dates and day counts, with random idle cycles on both channels save
// in one random phase. date_sub_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_date_minus_days;
  import dmd_pkg::*;

  localparam int          MAX_YEAR    = 9999;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          PHASE_ITEMS = 475;
  localparam int          DRAIN_WAIT  = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          no_idle = 1'b0;
  int unsigned cycles = 0;
  int unsigned fail_count;
  int unsigned pending;

  dmd_req_if req_ch ();
  dmd_rsp_if rsp_ch ();

  date_minus_days #(.MAX_YEAR(MAX_YEAR)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  date_sub_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL date_minus_days");
      $finish;
    end
  end

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.start_day   = '0;
    req_ch.start_month = '0;
    req_ch.start_year  = '0;
    req_ch.days_back   = '0;
    rsp_ch.ready       = 1'b0;
  end

  task automatic send_request(input logic [DAY_W-1:0]  d,
                              input logic [MON_W-1:0]  m,
                              input logic [YEAR_W-1:0] y,
                              input logic [BACK_W-1:0] back);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.start_day   = d;
    req_ch.start_month = m;
    req_ch.start_year  = y;
    req_ch.days_back   = back;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_random;
    logic [DAY_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    logic [BACK_W-1:0] back;
    int unsigned       k;
    k = $urandom_range(0, 99);
    if (k < 60) d = DAY_W'($urandom_range(1, 28));
    else if (k < 90) d = DAY_W'($urandom_range(1, 31));
    else d = DAY_W'($urandom_range(0, 31));
    k = $urandom_range(0, 99);
    m = (k < 90) ? MON_W'($urandom_range(1, 12)) : MON_W'($urandom_range(0, 15));
    k = $urandom_range(0, 99);
    if (k < 80) y = YEAR_W'($urandom_range(1, MAX_YEAR));
    else if (k < 90) y = YEAR_W'($urandom_range(0, 3));
    else y = YEAR_W'($urandom_range(0, 16383));
    k = $urandom_range(0, 99);
    if (y <= 3) back = BACK_W'($urandom_range(0, 1500));
    else if (k < 30) back = BACK_W'($urandom_range(0, 400));
    else if (k < 60) back = BACK_W'($urandom_range(0, 40000));
    else if (k < 85) back = BACK_W'($urandom_range(0, 3700000));
    else back = BACK_W'($urandom_range(0, 4194303));
    send_request(d, m, y, back);
  endtask

  task automatic wait_drained;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side
  initial begin
    int unsigned gap;
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first and last supported dates, clamp boundaries
    send_request(5'd1,  4'd1,  14'd1,    22'd0);
    send_request(5'd1,  4'd1,  14'd1,    22'd1);
    send_request(5'd31, 4'd12, 14'd9999, 22'd0);
    send_request(5'd31, 4'd12, 14'd9999, 22'd3652058);
    send_request(5'd31, 4'd12, 14'd9999, 22'd3652059);
    send_request(5'd31, 4'd12, 14'd9999, 22'd4194303);
    // leap days and century years
    send_request(5'd29, 4'd2,  14'd2000, 22'd0);
    send_request(5'd1,  4'd3,  14'd2000, 22'd1);
    send_request(5'd1,  4'd3,  14'd1900, 22'd1);
    send_request(5'd1,  4'd3,  14'd2024, 22'd1);
    send_request(5'd1,  4'd1,  14'd2001, 22'd1);
    send_request(5'd1,  4'd1,  14'd1901, 22'd1);
    send_request(5'd1,  4'd1,  14'd401,  22'd1);
    send_request(5'd1,  4'd1,  14'd5,    22'd1);
    // out-of-range month and year, day outside the month
    send_request(5'd15, 4'd0,  14'd1999, 22'd10);
    send_request(5'd15, 4'd15, 14'd1999, 22'd10);
    send_request(5'd10, 4'd6,  14'd0,    22'd0);
    send_request(5'd31, 4'd15, 14'd16383, 22'd0);
    send_request(5'd0,  4'd3,  14'd2023, 22'd0);
    send_request(5'd31, 4'd2,  14'd2023, 22'd0);
    send_request(5'd31, 4'd4,  14'd2023, 22'd0);
    send_request(5'd0,  4'd1,  14'd1,    22'd0);
    send_request(5'd0,  4'd0,  14'd0,    22'd4194303);
    @(negedge clk);
    req_ch.valid = 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      no_idle = (phase == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      @(negedge clk);
      req_ch.valid = 1'b0;
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS date_minus_days");
    end else begin
      $display("FAIL date_minus_days");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/dmd_pkg.sv
hw/rtl/dmd_req_if.sv
hw/rtl/dmd_rsp_if.sv
hw/rtl/dmd_datapath.sv
hw/rtl/dmd_ctrl.sv
hw/rtl/date_minus_days.sv
hw/rtl/dmd_checker.sv
verif/date_sub_checker.sv
verif/tb_date_minus_days.sv
